FILE: rtl/core/cau_pkg.sv
// cau_pkg: types, constants and helper functions of the complex arithmetic unit
// no dependencies; used by rtl/core/complex_arithmetic_unit.sv
package cau_pkg;

	localparam int DW        = 16;
	localparam int FB        = 8;
	localparam int CS        = 14;
	localparam int ANG_BITS  = 30;
	localparam int ATAN_ROWS = 24;

	localparam int PW     = 2 * DW;
	localparam int SW     = 2 * DW + 2;
	localparam int DIV_W  = 2 * DW + FB + 1;
	localparam int SQ_W   = 2 * DW + 1;
	localparam int CX_W   = 64;
	localparam int Z_W    = 34;
	localparam int MW     = 48;
	localparam int CSHIFT = 60 - DW;
	localparam int ITER   = DIV_W;
	localparam int LAT    = ITER + 4;

	typedef logic signed [DW-1:0] data_t;

	localparam data_t DMAX = data_t'((1 << (DW - 1)) - 1);
	localparam data_t DMIN = data_t'(1 << (DW - 1));

	localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [31:0] ATAN_Q30 [ATAN_ROWS] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
		32'd128
	};

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_MUL   = 3'd2,
		FN_DIV   = 3'd3,
		FN_MAG   = 3'd4,
		FN_PHASE = 3'd5
	} func_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		data_t      a_re;
		data_t      a_im;
		data_t      b_re;
		data_t      b_im;
	} cmd_t;

	typedef struct packed {
		data_t      res_re;
		data_t      res_im;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		data_t val;
		logic  sat;
	} sat_t;

	typedef struct packed {
		logic [2:0] func;
		rsp_t       early;
		logic       dz;
	} side_t;

	typedef struct packed {
		logic             neg_re;
		logic             neg_im;
		logic [PW-1:0]    d;
		logic [PW-1:0]    rem_re;
		logic [DIV_W-1:0] nq_re;
		logic [PW-1:0]    rem_im;
		logic [DIV_W-1:0] nq_im;
	} dv_t;

	typedef struct packed {
		logic [SQ_W-1:0] x;
		logic [SQ_W-1:0] r;
	} sq_t;

	typedef struct packed {
		logic                   hold;
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [Z_W-1:0]  cz;
	} cd_t;

	function automatic sat_t sat_sm(input logic neg, input logic [MW-1:0] mag);
		sat_t            o;
		logic [MW-1:0]   lim;
		lim   = MW'(1) << (DW - 1);
		o.sat = 1'b0;
		if (!neg) begin
			if (mag > lim - MW'(1)) begin
				o.val = DMAX;
				o.sat = 1'b1;
			end else begin
				o.val = data_t'(mag[DW-1:0]);
			end
		end else begin
			if (mag > lim) begin
				o.val = DMIN;
				o.sat = 1'b1;
			end else begin
				o.val = data_t'(~mag[DW-1:0] + 1'b1);
			end
		end
		return o;
	endfunction

	function automatic sat_t sat_s(input logic signed [MW-1:0] v);
		logic [MW-1:0] m;
		m = (v < 0) ? MW'(-v) : MW'(v);
		return sat_sm(v < 0, m);
	endfunction

endpackage

FILE: rtl/core/complex_arithmetic_unit.sv
// complex_arithmetic_unit: pipelined complex add, sub, mul, div, magnitude and phase
// depends on cau_pkg (types, constants, saturation helpers)
// done and res are output registers behind stages 1, 2 and 3; res is valid while done is high
// throughput: one item per cycle, busy is never raised; the 41-step divider sets the depth
// root and cordic run alongside the divider steps, so every function has the same latency
// reset clears the valid bits only; the pipeline is empty after reset
module complex_arithmetic_unit
	import cau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t res
);

	// stage 1: products and add/sub
	logic                   v_s1;
	logic [2:0]             func_s1;
	data_t                  are_s1, aim_s1;
	logic signed [DW:0]     as_re_s1, as_im_s1;
	logic signed [PW-1:0]   p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [PW-1:0]          sqa_s1, sqb_s1;

	logic signed [DW:0]     as_re, as_im;
	logic signed [PW-1:0]   m_rr, m_ii, m_ri, m_ir, m_qa, m_qb;
	data_t                  u_re, u_im;

	assign busy = 1'b0;

	always_comb begin
		if (cmd.func == FN_SUB) begin
			as_re = (DW+1)'(cmd.a_re) - (DW+1)'(cmd.b_re);
			as_im = (DW+1)'(cmd.a_im) - (DW+1)'(cmd.b_im);
		end else begin
			as_re = (DW+1)'(cmd.a_re) + (DW+1)'(cmd.b_re);
			as_im = (DW+1)'(cmd.a_im) + (DW+1)'(cmd.b_im);
		end
		u_re = (cmd.func == FN_MAG) ? cmd.a_re : cmd.b_re;
		u_im = (cmd.func == FN_MAG) ? cmd.a_im : cmd.b_im;
		m_rr = PW'(cmd.a_re) * PW'(cmd.b_re);
		m_ii = PW'(cmd.a_im) * PW'(cmd.b_im);
		m_ri = PW'(cmd.a_re) * PW'(cmd.b_im);
		m_ir = PW'(cmd.a_im) * PW'(cmd.b_re);
		m_qa = PW'(u_re) * PW'(u_re);
		m_qb = PW'(u_im) * PW'(u_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		func_s1  <= cmd.func;
		are_s1   <= cmd.a_re;
		aim_s1   <= cmd.a_im;
		as_re_s1 <= as_re;
		as_im_s1 <= as_im;
		p_rr_s1  <= m_rr;
		p_ii_s1  <= m_ii;
		p_ri_s1  <= m_ri;
		p_ir_s1  <= m_ir;
		sqa_s1   <= PW'(m_qa);
		sqb_s1   <= PW'(m_qb);
	end

	// stage 2: sums of products, add/sub saturation
	logic                 v_s2;
	logic [2:0]           func_s2;
	data_t                are_s2, aim_s2;
	rsp_t                 early_s2;
	logic signed [SW-1:0] pr_s2, pi_s2, nr_s2, ni_s2;
	logic [PW-1:0]        dsum_s2;

	logic signed [MW-1:0] w_re, w_im;
	sat_t                 s_re, s_im;
	rsp_t                 early_as;
	logic signed [SW-1:0] pr, pi, nr, ni;

	always_comb begin
		w_re = MW'(as_re_s1);
		w_im = MW'(as_im_s1);
		s_re = sat_s(w_re);
		s_im = sat_s(w_im);
		early_as.res_re = s_re.val;
		early_as.res_im = s_im.val;
		early_as.status = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
		pr = SW'(p_rr_s1);
		pr = pr - SW'(p_ii_s1);
		pi = SW'(p_ri_s1);
		pi = pi + SW'(p_ir_s1);
		nr = SW'(p_rr_s1);
		nr = nr + SW'(p_ii_s1);
		ni = SW'(p_ir_s1);
		ni = ni - SW'(p_ri_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2  <= func_s1;
		are_s2   <= are_s1;
		aim_s2   <= aim_s1;
		early_s2 <= early_as;
		pr_s2    <= pr;
		pi_s2    <= pi;
		nr_s2    <= nr;
		ni_s2    <= ni;
		dsum_s2  <= sqa_s1 + sqb_s1;
	end

	// stage 3 is index 0; index k+1 holds the state after iteration k
	logic  vld_s3  [ITER+1];
	side_t side_s3 [ITER+1];
	dv_t   dv_s3   [ITER+1];
	sq_t   sq_s3   [ITER+1];
	cd_t   cd_s3   [ITER+1];

	side_t                  side_in;
	dv_t                    dv_in;
	sq_t                    sq_in;
	cd_t                    cd_in;
	logic [SW-1:0]          mag_pr, mag_pi, mag_nr, mag_ni;
	logic [SW-1:0]          rnd_pr, rnd_pi;
	sat_t                   m_re, m_im;
	logic signed [CX_W-1:0] xa, ya;

	always_comb begin
		mag_pr = (pr_s2 < 0) ? SW'(-pr_s2) : SW'(pr_s2);
		mag_pi = (pi_s2 < 0) ? SW'(-pi_s2) : SW'(pi_s2);
		mag_nr = (nr_s2 < 0) ? SW'(-nr_s2) : SW'(nr_s2);
		mag_ni = (ni_s2 < 0) ? SW'(-ni_s2) : SW'(ni_s2);
		rnd_pr = (mag_pr + (SW'(1) << (FB - 1))) >> FB;
		rnd_pi = (mag_pi + (SW'(1) << (FB - 1))) >> FB;
		m_re   = sat_sm(pr_s2 < 0, MW'(rnd_pr));
		m_im   = sat_sm(pi_s2 < 0, MW'(rnd_pi));

		side_in.func = func_s2;
		side_in.dz   = (dsum_s2 == '0);
		case (func_s2)
			FN_ADD, FN_SUB: begin
				side_in.early = early_s2;
			end
			FN_MUL: begin
				side_in.early.res_re = m_re.val;
				side_in.early.res_im = m_im.val;
				side_in.early.status = (m_re.sat || m_im.sat) ? ST_SAT : ST_OK;
			end
			default: begin
				side_in.early = '0;
			end
		endcase

		dv_in.neg_re = (nr_s2 < 0);
		dv_in.neg_im = (ni_s2 < 0);
		dv_in.d      = dsum_s2;
		dv_in.rem_re = '0;
		dv_in.rem_im = '0;
		dv_in.nq_re  = DIV_W'(mag_nr) << (FB + 1);
		dv_in.nq_im  = DIV_W'(mag_ni) << (FB + 1);

		sq_in.x = SQ_W'(dsum_s2);
		sq_in.r = '0;

		xa = CX_W'(are_s2);
		ya = CX_W'(aim_s2);
		if (are_s2 < 0) begin
			xa = -xa;
			ya = -ya;
		end
		cd_in.hold = (are_s2 == '0);
		cd_in.cx   = xa <<< CSHIFT;
		cd_in.cy   = ya <<< CSHIFT;
		if (are_s2 < 0) begin
			cd_in.cz = PI_Q30;
		end else if (are_s2 == '0 && aim_s2 > 0) begin
			cd_in.cz = HALF_PI_Q30;
		end else if (are_s2 == '0 && aim_s2 < 0) begin
			cd_in.cz = -HALF_PI_Q30;
		end else begin
			cd_in.cz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3[0] <= 1'b0;
		end else begin
			vld_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3[0] <= side_in;
		dv_s3[0]   <= dv_in;
		sq_s3[0]   <= sq_in;
		cd_s3[0]   <= cd_in;
	end

	for (genvar k = 0; k < ITER; k++) begin : g_it
		dv_t             dv_nx;
		sq_t             sq_nx;
		cd_t             cd_nx;
		logic [PW-1:0]   t_re, t_im;

		// one quotient bit per lane
		always_comb begin
			dv_nx = dv_s3[k];
			t_re  = {dv_s3[k].rem_re[PW-2:0], dv_s3[k].nq_re[DIV_W-1]};
			t_im  = {dv_s3[k].rem_im[PW-2:0], dv_s3[k].nq_im[DIV_W-1]};
			if (t_re >= dv_s3[k].d) begin
				dv_nx.rem_re = t_re - dv_s3[k].d;
				dv_nx.nq_re  = {dv_s3[k].nq_re[DIV_W-2:0], 1'b1};
			end else begin
				dv_nx.rem_re = t_re;
				dv_nx.nq_re  = {dv_s3[k].nq_re[DIV_W-2:0], 1'b0};
			end
			if (t_im >= dv_s3[k].d) begin
				dv_nx.rem_im = t_im - dv_s3[k].d;
				dv_nx.nq_im  = {dv_s3[k].nq_im[DIV_W-2:0], 1'b1};
			end else begin
				dv_nx.rem_im = t_im;
				dv_nx.nq_im  = {dv_s3[k].nq_im[DIV_W-2:0], 1'b0};
			end
		end

		if (k < DW) begin : g_sq
			localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * DW - 2 - 2 * k);
			logic [SQ_W-1:0] trial;
			always_comb begin
				trial = sq_s3[k].r + SQ_BIT;
				if (sq_s3[k].x >= trial) begin
					sq_nx.x = sq_s3[k].x - trial;
					sq_nx.r = (sq_s3[k].r >> 1) + SQ_BIT;
				end else begin
					sq_nx.x = sq_s3[k].x;
					sq_nx.r = sq_s3[k].r >> 1;
				end
			end
		end else begin : g_sq_pass
			assign sq_nx = sq_s3[k];
		end

		if (k < CS) begin : g_cd
			logic signed [CX_W-1:0] dx, dy;
			always_comb begin
				cd_nx = cd_s3[k];
				dx    = cd_s3[k].cy >>> k;
				dy    = cd_s3[k].cx >>> k;
				if (!cd_s3[k].hold) begin
					if (cd_s3[k].cy > 0) begin
						cd_nx.cx = cd_s3[k].cx + dx;
						cd_nx.cy = cd_s3[k].cy - dy;
						cd_nx.cz = cd_s3[k].cz + Z_W'(ATAN_Q30[k]);
					end else begin
						cd_nx.cx = cd_s3[k].cx - dx;
						cd_nx.cy = cd_s3[k].cy + dy;
						cd_nx.cz = cd_s3[k].cz - Z_W'(ATAN_Q30[k]);
					end
				end
			end
		end else begin : g_cd_pass
			assign cd_nx = cd_s3[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k+1] <= 1'b0;
			end else begin
				vld_s3[k+1] <= vld_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s3[k+1] <= side_s3[k];
			dv_s3[k+1]   <= dv_nx;
			sq_s3[k+1]   <= sq_nx;
			cd_s3[k+1]   <= cd_nx;
		end
	end

	// result selection, rounding and saturation
	logic                done_q;
	rsp_t                res_q;
	rsp_t                fin;
	logic [MW-1:0]       q_re, q_im, sq_m;
	logic [Z_W-1:0]      z_mag;
	logic [Z_W-1:0]      z_rnd;
	sat_t                f_re, f_im;
	side_t               sd;
	dv_t                 dv;
	sq_t                 sq;
	cd_t                 cd;

	always_comb begin
		sd    = side_s3[ITER];
		dv    = dv_s3[ITER];
		sq    = sq_s3[ITER];
		cd    = cd_s3[ITER];
		q_re  = (MW'(dv.nq_re) + MW'(1)) >> 1;
		q_im  = (MW'(dv.nq_im) + MW'(1)) >> 1;
		sq_m  = (sq.x > sq.r) ? MW'(sq.r) + MW'(1) : MW'(sq.r);
		z_mag = (cd.cz < 0) ? Z_W'(-cd.cz) : Z_W'(cd.cz);
		z_rnd = (z_mag + (Z_W'(1) << (ANG_BITS - FB - 1))) >> (ANG_BITS - FB);
		f_re  = '0;
		f_im  = '0;
		fin   = '0;
		case (sd.func)
			FN_ADD, FN_SUB, FN_MUL: begin
				fin = sd.early;
			end
			FN_DIV: begin
				if (sd.dz) begin
					fin.status = ST_DIVZ;
				end else begin
					f_re       = sat_sm(dv.neg_re, q_re);
					f_im       = sat_sm(dv.neg_im, q_im);
					fin.res_re = f_re.val;
					fin.res_im = f_im.val;
					fin.status = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
				end
			end
			FN_MAG: begin
				f_re       = sat_sm(1'b0, sq_m);
				fin.res_re = f_re.val;
				fin.status = f_re.sat ? ST_SAT : ST_OK;
			end
			FN_PHASE: begin
				f_re       = sat_sm(cd.cz < 0, MW'(z_rnd));
				fin.res_re = f_re.val;
				fin.status = f_re.sat ? ST_SAT : ST_OK;
			end
			default: begin
				fin = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3[ITER];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= fin;
	end

	assign done = done_q;
	assign res  = res_q;

	// every transfer in comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("transfer lost in pipeline");

	// nothing comes out that was not in the last stage
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s3[ITER] |=> !done)
		else $error("spurious result strobe");

	// divide by zero gives a zero result
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_DIVZ) |-> (res.res_re == '0 && res.res_im == '0))
		else $error("divide by zero with non-zero result");

	// a saturation flag comes with a clamped component
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_SAT) |->
		(res.res_re == DMAX || res.res_re == DMIN ||
		 res.res_im == DMAX || res.res_im == DMIN))
		else $error("saturation flag without clamped value");

endmodule

FILE: test/tb.sv
// tb: self-checking testbench for complex_arithmetic_unit, predicts every result in-line
// depends on cau_pkg and rtl/core/complex_arithmetic_unit.sv
// directed corner cases, then random streams with varying sender gaps
`timescale 1ns / 100ps

module tb;
	import cau_pkg::*;

	localparam logic [2:0] FN_SPARE_LO = 3'd6;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_LIMIT = 2000;
	localparam longint PI_ANG = 64'sd3373259426;
	localparam longint HALF_PI_ANG = 64'sd1686629713;
	localparam longint ATAN_ANG [14] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t res;

	rsp_t result_q [$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int idle_pct = 0;
	int quiet = 0;
	int func_count [8];

	complex_arithmetic_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic data_t clamp(input longint v, inout bit flag);
		if (v > 32767) begin
			flag = 1'b1;
			return DMAX;
		end
		if (v < -32768) begin
			flag = 1'b1;
			return DMIN;
		end
		return data_t'(v);
	endfunction

	// round off s bits, ties away from zero
	function automatic longint round_away(input longint v, input int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint quot_round(input longint n, input longint d);
		longint m;
		m = (n < 0) ? -n : n;
		m = (((m <<< (FB + 1)) / d) + 1) >>> 1;
		return (n < 0) ? -m : m;
	endfunction

	function automatic longint root_round(input longint unsigned n);
		longint unsigned x, r, b;
		x = n;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (n - r * r > r) r++;
		return longint'(r);
	endfunction

	function automatic longint vector_angle(input longint x0, input longint y0);
		longint x, y, z, dx, dy;
		x = x0 <<< (60 - DW);
		y = y0 <<< (60 - DW);
		z = 0;
		for (int i = 0; i < 14; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ATAN_ANG[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_ANG[i];
			end
		end
		return z;
	endfunction

	function automatic rsp_t complex_result(input cmd_t c);
		rsp_t r;
		bit sat;
		longint ar, ai, br, bi, d, z;
		ar = c.a_re;
		ai = c.a_im;
		br = c.b_re;
		bi = c.b_im;
		sat = 1'b0;
		r = '0;
		r.status = ST_OK;
		case (c.func)
			FN_ADD: begin
				r.res_re = clamp(ar + br, sat);
				r.res_im = clamp(ai + bi, sat);
			end
			FN_SUB: begin
				r.res_re = clamp(ar - br, sat);
				r.res_im = clamp(ai - bi, sat);
			end
			FN_MUL: begin
				r.res_re = clamp(round_away(ar * br - ai * bi, FB), sat);
				r.res_im = clamp(round_away(ar * bi + ai * br, FB), sat);
			end
			FN_DIV: begin
				d = br * br + bi * bi;
				if (d == 0) begin
					r.status = ST_DIVZ;
				end else begin
					r.res_re = clamp(quot_round(ar * br + ai * bi, d), sat);
					r.res_im = clamp(quot_round(ai * br - ar * bi, d), sat);
				end
			end
			FN_MAG: r.res_re = clamp(root_round(ar * ar + ai * ai), sat);
			FN_PHASE: begin
				if (ar > 0) z = vector_angle(ar, ai);
				else if (ar < 0) z = vector_angle(-ar, -ai) + PI_ANG;
				else if (ai > 0) z = HALF_PI_ANG;
				else if (ai < 0) z = -HALF_PI_ANG;
				else z = 0;
				r.res_re = clamp(round_away(z, ANG_BITS - FB), sat);
			end
			default: ;
		endcase
		if (r.status == ST_OK && sat) r.status = ST_SAT;
		return r;
	endfunction

	function automatic cmd_t mk(input logic [2:0] f, input longint ar, input longint ai,
			input longint br, input longint bi);
		cmd_t c;
		c.func = f;
		c.a_re = data_t'(ar);
		c.a_im = data_t'(ai);
		c.b_re = data_t'(br);
		c.b_im = data_t'(bi);
		return c;
	endfunction

	function automatic data_t rand_val();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DMAX;
			2: return DMIN;
			3, 4: return data_t'(int'($urandom_range(0, 1023)) - 512);
			5: return data_t'(int'($urandom_range(0, 15)) - 8);
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.func = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI))
			: 3'($urandom_range(FN_ADD, FN_PHASE));
		c.a_re = rand_val();
		c.a_im = rand_val();
		c.b_re = rand_val();
		c.b_im = rand_val();
		return c;
	endfunction

	task automatic send_item(input cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		result_q.push_back(complex_result(c));
		func_count[c.func]++;
		n_sent++;
		// each following cycle stays idle with the given percentage
		while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			cmd <= cmd_t'({$urandom, $urandom, $urandom});
			@(posedge clk);
		end
	endtask

	// result check and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
			if (done) begin
				if (result_q.size() == 0) begin
					$error("result with no transfer pending");
					errors++;
				end else begin
					rsp_t e;
					e = result_q.pop_front();
					n_checked++;
					if (res.res_re !== e.res_re) begin
						$error("res_re: expected %0d, got %0d", e.res_re, res.res_re);
						errors++;
					end
					if (res.res_im !== e.res_im) begin
						$error("res_im: expected %0d, got %0d", e.res_im, res.res_im);
						errors++;
					end
					if (res.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, res.status);
						errors++;
					end
				end
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send_item(mk(FN_ADD, 32767, 32767, 32767, 1));
		send_item(mk(FN_ADD, -32768, -32768, -1, 0));
		send_item(mk(FN_SUB, -32768, 0, 32767, -32768));
		send_item(mk(FN_SUB, 256, -256, 0, 0));
		send_item(mk(FN_MUL, 32767, 32767, 32767, -32768));
		send_item(mk(FN_MUL, -32768, -32768, -32768, -32768));
		send_item(mk(FN_MUL, 1, 0, 128, 0));
		send_item(mk(FN_MUL, -1, 0, 128, 0));
		send_item(mk(FN_MUL, 512, 256, -384, 128));
		send_item(mk(FN_DIV, 1000, -700, 0, 0));
		send_item(mk(FN_DIV, -32768, 100, 1, 0));
		send_item(mk(FN_DIV, 768, 512, 256, -256));
		send_item(mk(FN_DIV, 1, 0, 512, 0));
		send_item(mk(FN_DIV, 32767, -32768, -32768, 32767));
		send_item(mk(FN_MAG, 768, 1024, 0, 0));
		send_item(mk(FN_MAG, -32768, -32768, 5, 5));
		send_item(mk(FN_PHASE, 256, 256, 0, 0));
		send_item(mk(FN_PHASE, -256, -1, 0, 0));
		send_item(mk(FN_PHASE, -256, 0, 0, 0));
		send_item(mk(FN_PHASE, 0, 300, 0, 0));
		send_item(mk(FN_PHASE, 0, -300, 0, 0));
		send_item(mk(FN_PHASE, 0, 0, 0, 0));
		send_item(mk(FN_SPARE_LO, 1234, -5, 77, 9));
		send_item(mk(FN_SPARE_HI, -32768, 32767, -1, 1));
	endtask

	task automatic test_random_stream(input int pct, input int count);
		idle_pct = pct;
		repeat (count) send_item(rand_cmd());
	endtask

	task automatic test_back_to_back();
		test_random_stream(0, 570);
	endtask

	task automatic test_sender_gaps();
		test_random_stream(59, 570);
	endtask

	task automatic test_mixed_gaps();
		test_random_stream(37, 570);
	endtask

	initial begin
		int guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sender_gaps();
		test_mixed_gaps();
		start <= 1'b0;
		guard = 0;
		while (result_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d results never arrived", result_q.size());
			errors++;
		end
		$display("sent %0d commands, checked %0d results; add %0d sub %0d mul %0d div %0d",
			n_sent, n_checked, func_count[FN_ADD], func_count[FN_SUB], func_count[FN_MUL],
			func_count[FN_DIV]);
		$display("magnitude %0d phase %0d unused codes %0d", func_count[FN_MAG],
			func_count[FN_PHASE], func_count[FN_SPARE_LO] + func_count[FN_SPARE_HI]);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: complex_arithmetic_unit.f
rtl/core/cau_pkg.sv
rtl/core/complex_arithmetic_unit.sv
test/tb.sv
